// File: src/linear_probe_hash_table_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the linear probe hash table core
// Each check can be compiled out by defining NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef LINEAR_PROBE_HASH_TABLE_CORE_DEFINES_SVH
`define LINEAR_PROBE_HASH_TABLE_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define LPHT_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define LPHT_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define LPHT_ASSERT_IMP(label, ante, cons, msg)
`define LPHT_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

// File: src/lpht_pkg.sv
// ----------------------------------------------------------------------------
// lpht_pkg
// Sizes, codes and types shared by the linear probe hash table core.
// ----------------------------------------------------------------------------
package lpht_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = ADDR_W + 1;
	localparam int KEY_W       = 32;
	localparam int VAL_W       = 32;
	localparam int OUT_CNT_W   = 11;

	localparam logic [KEY_W-1:0] RESERVED_KEY = {KEY_W{1'b1}};

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_LOOKUP = 2'd1,
		OP_REMOVE = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_MISS     = 2'd1,
		ST_FULL     = 2'd2,
		ST_RESERVED = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_PROBE,
		S_SHIFT,
		S_CLOSE
	} state_t;

	typedef struct packed {
		logic             valid;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} entry_t;

endpackage

// File: src/linear_probe_hash_table_core.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_table_core
// Open-addressing key/value map with linear probing and backward-shift delete.
// Lookup and insert probe one slot after another from the key's home slot;
//   remove then scans the slots past the freed one, shifts entries back and
//   clears the last hole; reserved key or unknown op answers from idle.
// Throughput: one op at a time, a new start is taken in the cycle done is high.
// Reset: sweeps the slot RAM, clearing every slot, with busy high.
// ----------------------------------------------------------------------------
`include "linear_probe_hash_table_core_defines.svh"

module linear_probe_hash_table_core
	import lpht_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [1:0]           operation,
	input  logic [KEY_W-1:0]     key,
	input  logic [VAL_W-1:0]     value,
	output logic                 done,
	output logic [1:0]           status,
	output logic [VAL_W-1:0]     found_value,
	output logic [OUT_CNT_W-1:0] entry_count
);

	entry_t            mem [TABLE_DEPTH];
	entry_t            rd_q;
	logic [ADDR_W-1:0] rd_addr;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	entry_t            wr_data;

	state_t            state_q, state_d;
	op_t               op_q;
	logic [KEY_W-1:0]  key_q;
	logic [VAL_W-1:0]  val_q;
	logic [ADDR_W-1:0] addr_q;
	logic [ADDR_W-1:0] hole_q;
	logic [ADDR_W-1:0] step_q;
	logic [CNT_W-1:0]  cnt_q, cnt_d;

	logic              done_q;
	status_t           status_q;
	logic [VAL_W-1:0]  found_q;
	logic [OUT_CNT_W-1:0] ecount_q;

	logic              accept;
	logic              hit, empty, last, move;
	logic [ADDR_W-1:0] dist_home, dist_hole;
	logic              fin;
	status_t           fin_status;
	logic [VAL_W-1:0]  fin_found;
	logic              to_shift;

	assign accept    = start && (state_q == S_IDLE);
	assign hit       = rd_q.valid && (rd_q.key == key_q);
	assign empty     = !rd_q.valid;
	assign last      = &step_q;
	assign dist_home = addr_q - rd_q.key[ADDR_W-1:0];
	assign dist_hole = addr_q - hole_q;
	assign move      = (dist_home >= dist_hole);
	assign to_shift  = (state_q == S_PROBE) && hit && (op_q == OP_REMOVE);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (&addr_q) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start && key != RESERVED_KEY && op_t'(operation) != OP_NONE) begin
					state_d = S_PROBE;
				end
			end
			S_PROBE: begin
				if (to_shift) begin
					state_d = S_SHIFT;
				end else if (hit || empty || last) begin
					state_d = S_IDLE;
				end
			end
			S_SHIFT: begin
				if (empty || last) begin
					state_d = S_CLOSE;
				end
			end
			S_CLOSE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// memory controls and result
	always_comb begin
		rd_addr    = addr_q + 1'b1;
		wr_en      = 1'b0;
		wr_addr    = addr_q;
		wr_data    = '{valid: 1'b1, key: key_q, value: val_q};
		fin        = 1'b0;
		fin_status = ST_MISS;
		fin_found  = '0;
		cnt_d      = cnt_q;
		unique case (state_q)
			S_CLEAR: begin
				wr_en   = 1'b1;
				wr_data = '0;
			end
			S_IDLE: begin
				rd_addr = key[ADDR_W-1:0];
				if (start) begin
					if (key == RESERVED_KEY) begin
						fin        = 1'b1;
						fin_status = ST_RESERVED;
					end else if (op_t'(operation) == OP_NONE) begin
						fin        = 1'b1;
						fin_status = ST_MISS;
					end
				end
			end
			S_PROBE: begin
				if (hit) begin
					case (op_q)
						OP_INSERT: begin
							wr_en      = 1'b1;
							fin        = 1'b1;
							fin_status = ST_OK;
						end
						OP_LOOKUP: begin
							fin        = 1'b1;
							fin_status = ST_OK;
							fin_found  = rd_q.value;
						end
						default: begin
						end
					endcase
				end else if (empty) begin
					fin = 1'b1;
					if (op_q == OP_INSERT) begin
						wr_en      = 1'b1;
						fin_status = ST_OK;
						cnt_d      = cnt_q + 1'b1;
					end
				end else if (last) begin
					fin        = 1'b1;
					fin_status = (op_q == OP_INSERT) ? ST_FULL : ST_MISS;
				end
			end
			S_SHIFT: begin
				if (!empty && move) begin
					wr_en   = 1'b1;
					wr_addr = hole_q;
					wr_data = rd_q;
				end
			end
			S_CLOSE: begin
				wr_en      = 1'b1;
				wr_addr    = hole_q;
				wr_data    = '0;
				fin        = 1'b1;
				fin_status = ST_OK;
				if (cnt_q != '0) begin
					cnt_d = cnt_q - 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			addr_q  <= '0;
			step_q  <= '0;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			done_q  <= fin;
			unique case (state_q)
				S_CLEAR: begin
					addr_q <= addr_q + 1'b1;
				end
				S_IDLE: begin
					addr_q <= key[ADDR_W-1:0];
					step_q <= '0;
				end
				S_PROBE: begin
					addr_q <= addr_q + 1'b1;
					step_q <= to_shift ? ADDR_W'(1) : step_q + 1'b1;
				end
				S_SHIFT: begin
					addr_q <= addr_q + 1'b1;
					step_q <= step_q + 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= op_t'(operation);
			key_q <= key;
			val_q <= value;
		end
		if (state_q == S_PROBE) begin
			hole_q <= addr_q;
		end else if (state_q == S_SHIFT && !empty && move) begin
			hole_q <= addr_q;
		end
		if (fin) begin
			status_q <= fin_status;
			found_q  <= fin_found;
			ecount_q <= OUT_CNT_W'(cnt_d);
		end
	end

	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign status      = status_q;
	assign found_value = found_q;
	assign entry_count = ecount_q;

	`LPHT_ASSERT_IMP(a_done_not_busy, done, !busy, "result beat while busy")
	`LPHT_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(TABLE_DEPTH), "entry count above depth")
	`LPHT_ASSERT_IMP(a_shift_no_collide, wr_en && state_q == S_SHIFT && !last,
		wr_addr != rd_addr, "shift write hits the slot being read")
	`LPHT_ASSERT_NXT(a_cnt_moves_with_done, state_q != S_CLEAR && cnt_d != cnt_q, done,
		"entry count changed without a result beat")
	`LPHT_ASSERT_IMP(a_reserved_status, done && status == ST_RESERVED,
		key_q == RESERVED_KEY, "reserved status for an ordinary key")

endmodule
